@@ rtl/core/ssht_pkg.sv @@
// ----------------------------------------------------------------------------
// Scoped symbol hash table package
// Shared sizes, item and status codes, and the stored slot layout.
// ----------------------------------------------------------------------------
package ssht_pkg;

	localparam int BUCKET_COUNT     = 30;
	localparam int SLOTS_PER_BUCKET = 8;
	localparam int MAX_NAME_CHARS   = 8;

	localparam int TOTAL_SLOTS = BUCKET_COUNT * SLOTS_PER_BUCKET;
	localparam int ADDR_W      = $clog2(TOTAL_SLOTS);
	localparam int SLOT_W      = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
	localparam int ISSUE_W     = $clog2(SLOTS_PER_BUCKET + 1);
	localparam int BUCKET_W    = $clog2(BUCKET_COUNT);

	// Hash datapath: sum of byte * position, then remainder by BUCKET_COUNT
	localparam int WEIGHT_W = $clog2(MAX_NAME_CHARS + 1);
	localparam int SUM_MAX  = 255 * MAX_NAME_CHARS * (MAX_NAME_CHARS + 1) / 2;
	localparam int SUM_W    = $clog2(SUM_MAX + 1);
	localparam int PROD_W   = 8 + WEIGHT_W;

	// Reciprocal of BUCKET_COUNT, exact for every sum below 2**SUM_W
	localparam int RECIP_SHIFT = SUM_W + BUCKET_W;
	localparam int RECIP       = ((1 << RECIP_SHIFT) + BUCKET_COUNT - 1) / BUCKET_COUNT;
	localparam int RECIP_W     = $clog2(RECIP + 1);
	localparam int QPROD_W     = SUM_W + RECIP_W;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_SEARCH = 2'd1,
		KIND_UPDATE = 2'd2,
		KIND_POP    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_NOTFOUND = 2'd1,
		STAT_FULL     = 2'd2
	} status_t;

	typedef struct packed {
		logic [63:0] name;
		logic [3:0]  len;
		logic [31:0] value;
		logic [7:0]  level;
	} entry_t;

endpackage

@@ rtl/core/ssht_hash.sv @@
// ----------------------------------------------------------------------------
// Scoped symbol hash table: bucket hash unit
// One multiply-accumulate per character, then the remainder by BUCKET_COUNT
// through a reciprocal multiply: quotient registered in H_QUO, remainder in H_REM.
// ----------------------------------------------------------------------------
module ssht_hash import ssht_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [63:0]         name,
	output logic                done,
	output logic [BUCKET_W-1:0] bucket
);

	typedef enum logic [1:0] {
		H_IDLE,
		H_ACC,
		H_QUO,
		H_REM
	} hstate_t;

	hstate_t             state_q;
	logic [63:0]         name_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SUM_W-1:0]    quo_q;

	logic [PROD_W-1:0]   prod;
	logic [QPROD_W-1:0]  recip_prod;
	logic [SUM_W-1:0]    quo_times;
	logic [SUM_W-1:0]    rem_full;

	assign prod       = PROD_W'(name_q[7:0]) * PROD_W'(weight_q);
	assign recip_prod = QPROD_W'(sum_q) * QPROD_W'(RECIP);
	assign quo_times  = quo_q * SUM_W'(BUCKET_COUNT);
	assign rem_full   = sum_q - quo_times;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= H_IDLE;
			name_q   <= '0;
			weight_q <= '0;
			sum_q    <= '0;
			quo_q    <= '0;
			done     <= 1'b0;
			bucket   <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				H_IDLE: begin
					if (start) begin
						name_q   <= name;
						weight_q <= WEIGHT_W'(1);
						sum_q    <= '0;
						state_q  <= H_ACC;
					end
				end
				H_ACC: begin
					sum_q  <= sum_q + SUM_W'(prod);
					name_q <= name_q >> 8;
					if (weight_q == WEIGHT_W'(MAX_NAME_CHARS)) begin
						state_q <= H_QUO;
					end else begin
						weight_q <= weight_q + WEIGHT_W'(1);
					end
				end
				H_QUO: begin
					quo_q   <= SUM_W'(recip_prod >> RECIP_SHIFT);
					state_q <= H_REM;
				end
				H_REM: begin
					bucket  <= BUCKET_W'(rem_full);
					done    <= 1'b1;
					state_q <= H_IDLE;
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/scoped_symbol_hash_table_unit.sv @@
// ----------------------------------------------------------------------------
// Scoped symbol hash table
// Symbol store keyed by name and scope level, hashed into fixed-size buckets.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one operation per beat: insert,
// search, update value, or pop scope within one bucket. Output channel
// (out_valid / out_stall) returns one result beat per operation, in order.
// in_stall is high while an operation is in progress; the block handles one
// operation at a time.
// Sequence: accept, hash accumulation over MAX_NAME_CHARS characters, quotient
// and remainder, hand-over of the bucket, then a scan of the bucket that
// reads one slot per cycle from the single-port slot memory (up to
// SLOTS_PER_BUCKET slots, fewer when an insert, search or update hits
// early), then the load of the output register; a pop with an out-of-range
// bucket skips the scan. The next beat is accepted in the cycle after the
// result is loaded.
// Reset clears every slot valid bit at once; no clearing pass is needed.
// When the receiver stalls, the finished result holds in the output register
// and the next operation is still accepted; it waits only if it finishes
// before the earlier result has been taken.
// ----------------------------------------------------------------------------
module scoped_symbol_hash_table_unit import ssht_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [63:0] name_chars,
	input  logic [3:0]  name_length,
	input  logic signed [31:0] new_value,
	input  logic [7:0]  scope_level,
	input  logic [4:0]  bucket_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic signed [31:0] read_value,
	output logic [4:0]  hashed_bucket
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HASH,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t               state_q;
	kind_t                kind_q;
	logic [63:0]          name_q;
	logic [3:0]           len_q;
	logic [31:0]          val_q;
	logic [7:0]           lvl_q;
	logic [4:0]           bidx_q;
	logic [BUCKET_W-1:0]  bucket_q;
	logic [ADDR_W-1:0]    base_q;
	logic [ISSUE_W-1:0]   issue_q;
	logic [TOTAL_SLOTS-1:0] valid_q;
	status_t              res_status_q;
	logic [31:0]          res_read_q;

	logic                 cmp_vld_s1;
	logic [SLOT_W-1:0]    cmp_idx_s1;
	logic [ADDR_W-1:0]    cmp_addr_s1;
	logic                 cmp_valid_s1;
	entry_t               rd_data_s1;

	entry_t               mem [TOTAL_SLOTS];

	logic                 in_accept;
	logic [3:0]           len_sat;
	logic [63:0]          name_masked;
	logic                 hash_done;
	logic [BUCKET_W-1:0]  hash_bucket;
	logic                 pop_range_bad;
	logic [ADDR_W-1:0]    issue_addr;
	logic                 issue_en;
	logic                 lvl_match;
	logic                 full_match;
	logic                 hit;
	logic                 last_slot;
	logic                 finish;
	logic                 mem_we;
	logic                 out_load;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	// Saturate the length and zero every byte past it
	always_comb begin
		len_sat = (name_length > 4'(MAX_NAME_CHARS)) ? 4'(MAX_NAME_CHARS) : name_length;
		for (int j = 0; j < 8; j++) begin
			name_masked[8*j +: 8] = (4'(j) < len_sat) ? name_chars[8*j +: 8] : 8'd0;
		end
	end

	ssht_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_accept),
		.name   (name_masked),
		.done   (hash_done),
		.bucket (hash_bucket)
	);

	assign pop_range_bad = (9'(bidx_q) >= 9'(BUCKET_COUNT));

	// Scan: issue one slot read per cycle, compare it the cycle after
	assign issue_addr = base_q + ADDR_W'(issue_q);
	assign issue_en   = (state_q == ST_SCAN) && (issue_q < ISSUE_W'(SLOTS_PER_BUCKET))
		&& !finish;

	assign lvl_match  = (rd_data_s1.level == lvl_q);
	assign full_match = cmp_valid_s1 && lvl_match && (rd_data_s1.len == len_q)
		&& (rd_data_s1.name == name_q);

	always_comb begin
		case (kind_q)
			KIND_INSERT: hit = !cmp_valid_s1;
			KIND_POP:    hit = cmp_valid_s1 && lvl_match;
			default:     hit = full_match;
		endcase
	end

	assign last_slot = (cmp_idx_s1 == SLOT_W'(SLOTS_PER_BUCKET - 1));
	assign finish    = (state_q == ST_SCAN) && cmp_vld_s1
		&& ((hit && kind_q != KIND_POP) || last_slot);
	assign mem_we    = (state_q == ST_SCAN) && cmp_vld_s1 && hit
		&& (kind_q == KIND_INSERT || kind_q == KIND_UPDATE);
	assign out_load  = (state_q == ST_DONE) && (!out_valid || !out_stall);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cmp_addr_s1] <= '{name: name_q, len: len_q, value: val_q, level: lvl_q};
		end
		if (issue_en) begin
			rd_data_s1 <= mem[issue_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			kind_q        <= KIND_INSERT;
			name_q        <= '0;
			len_q         <= '0;
			val_q         <= '0;
			lvl_q         <= '0;
			bidx_q        <= '0;
			bucket_q      <= '0;
			base_q        <= '0;
			issue_q       <= '0;
			valid_q       <= '0;
			res_status_q  <= STAT_OK;
			res_read_q    <= '0;
			cmp_vld_s1    <= 1'b0;
			cmp_idx_s1    <= '0;
			cmp_addr_s1   <= '0;
			cmp_valid_s1  <= 1'b0;
			out_valid     <= 1'b0;
			status        <= '0;
			read_value    <= '0;
			hashed_bucket <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						kind_q  <= kind_t'(kind);
						name_q  <= name_masked;
						len_q   <= len_sat;
						val_q   <= new_value;
						lvl_q   <= scope_level;
						bidx_q  <= bucket_index;
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (hash_done) begin
						bucket_q     <= hash_bucket;
						issue_q      <= '0;
						cmp_vld_s1   <= 1'b0;
						res_read_q   <= '0;
						if (kind_q == KIND_POP) begin
							base_q <= ADDR_W'(int'(bidx_q) * SLOTS_PER_BUCKET);
						end else begin
							base_q <= ADDR_W'(int'(hash_bucket) * SLOTS_PER_BUCKET);
						end
						if (kind_q == KIND_POP && pop_range_bad) begin
							res_status_q <= STAT_NOTFOUND;
							state_q      <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					cmp_vld_s1 <= issue_en;
					if (issue_en) begin
						issue_q      <= issue_q + ISSUE_W'(1);
						cmp_idx_s1   <= SLOT_W'(issue_q);
						cmp_addr_s1  <= issue_addr;
						cmp_valid_s1 <= valid_q[issue_addr];
					end
					if (cmp_vld_s1 && hit) begin
						unique case (kind_q)
							KIND_INSERT: valid_q[cmp_addr_s1] <= 1'b1;
							KIND_POP:    valid_q[cmp_addr_s1] <= 1'b0;
							KIND_SEARCH: res_read_q <= rd_data_s1.value;
							default:     ;
						endcase
					end
					if (finish) begin
						if (kind_q == KIND_POP || hit) begin
							res_status_q <= STAT_OK;
						end else if (kind_q == KIND_INSERT) begin
							res_status_q <= STAT_FULL;
						end else begin
							res_status_q <= STAT_NOTFOUND;
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (out_load) begin
				out_valid     <= 1'b1;
				status        <= res_status_q;
				read_value    <= res_read_q;
				hashed_bucket <= 5'(bucket_q);
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

@@ tb/sv/scoped_symbol_hash_table_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scoped symbol hash table testbench
// Drives insert, search, update and pop-scope beats with random idling on both
// channels, mirrors the slot store in a scoreboard and checks every reply in
// order against the mirrored result.
// ----------------------------------------------------------------------------
module scoped_symbol_hash_table_unit_test;
	import ssht_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 300;
	localparam int DRAIN_CYCLES   = 40;
	localparam int POOL_SIZE      = 24;
	localparam int ROUND_ITEMS    = 250;

	typedef struct {
		status_t            status;
		logic signed [31:0] value;
		logic [4:0]         bucket;
	} reply_t;

	class symtab_mirror;
		bit [63:0] slot_name  [TOTAL_SLOTS];
		bit [3:0]  slot_len   [TOTAL_SLOTS];
		bit [31:0] slot_value [TOTAL_SLOTS];
		bit [7:0]  slot_level [TOTAL_SLOTS];
		bit        slot_used  [TOTAL_SLOTS];
		reply_t    replies_due [$];
		int        faults;

		function int unsigned bucket_for(logic [63:0] chars, int unsigned len);
			int unsigned acc;
			acc = 0;
			for (int i = 0; i < len; i++)
				acc += chars[8*i +: 8] * (i + 1);
			return acc % BUCKET_COUNT;
		endfunction

		// Apply one accepted beat to the mirrored store and queue its reply.
		function void apply_op(kind_t op, logic [63:0] chars_in, logic [3:0] len_in,
				logic signed [31:0] val, logic [7:0] lvl, logic [4:0] bidx);
			reply_t      r;
			int unsigned len;
			logic [63:0] chars;
			int unsigned base;
			int          hit;
			len = (len_in > MAX_NAME_CHARS) ? MAX_NAME_CHARS : len_in;
			chars = chars_in;
			if (len < 8)
				chars = chars_in & ((64'd1 << (8 * len)) - 64'd1);
			r.bucket = 5'(bucket_for(chars, len));
			r.status = STAT_OK;
			r.value = '0;
			base = r.bucket * SLOTS_PER_BUCKET;
			case (op)
				KIND_INSERT: begin
					r.status = STAT_FULL;
					for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
						if (!slot_used[base + s]) begin
							slot_used[base + s] = 1'b1;
							slot_name[base + s] = chars;
							slot_len[base + s] = 4'(len);
							slot_value[base + s] = val;
							slot_level[base + s] = lvl;
							r.status = STAT_OK;
							break;
						end
					end
				end
				KIND_SEARCH, KIND_UPDATE: begin
					hit = -1;
					for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
						if (slot_used[base + s] && slot_len[base + s] == len &&
								slot_name[base + s] == chars && slot_level[base + s] == lvl) begin
							hit = base + s;
							break;
						end
					end
					if (hit < 0)
						r.status = STAT_NOTFOUND;
					else if (op == KIND_SEARCH)
						r.value = slot_value[hit];
					else
						slot_value[hit] = val;
				end
				default: begin
					if (bidx >= BUCKET_COUNT) begin
						r.status = STAT_NOTFOUND;
					end else begin
						for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
							if (slot_used[bidx * SLOTS_PER_BUCKET + s] &&
									slot_level[bidx * SLOTS_PER_BUCKET + s] == lvl) begin
								slot_used[bidx * SLOTS_PER_BUCKET + s] = 1'b0;
								slot_name[bidx * SLOTS_PER_BUCKET + s] = '0;
								slot_len[bidx * SLOTS_PER_BUCKET + s] = '0;
								slot_value[bidx * SLOTS_PER_BUCKET + s] = '0;
								slot_level[bidx * SLOTS_PER_BUCKET + s] = '0;
							end
						end
					end
				end
			endcase
			replies_due.push_back(r);
		endfunction

		function void check_reply(logic [1:0] st, logic signed [31:0] rv, logic [4:0] hb);
			reply_t want;
			if (replies_due.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("%0t: reply with none pending: status %0d value %0d bucket %0d",
						$realtime, st, rv, hb);
				return;
			end
			want = replies_due.pop_front();
			if (st !== want.status || rv !== want.value || hb !== want.bucket) begin
				faults++;
				if (faults <= 10)
					$display("%0t: reply mismatch: status %0d/%0d value %0d/%0d bucket %0d/%0d (want/got)",
						$realtime, want.status, st, want.value, rv, want.bucket, hb);
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         kind;
	logic [63:0]        name_chars;
	logic [3:0]         name_length;
	logic signed [31:0] new_value;
	logic [7:0]         scope_level;
	logic [4:0]         bucket_index;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         status;
	logic signed [31:0] read_value;
	logic [4:0]         hashed_bucket;

	symtab_mirror sb = new;
	int           sent_count = 0;
	bit           send_eager = 1'b0;
	int           quiet_cycles = 0;

	scoped_symbol_hash_table_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.name_chars    (name_chars),
		.name_length   (name_length),
		.new_value     (new_value),
		.scope_level   (scope_level),
		.bucket_index  (bucket_index),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.read_value    (read_value),
		.hashed_bucket (hashed_bucket)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.apply_op(kind_t'(kind), name_chars, name_length, new_value, scope_level,
				bucket_index);
		if (arst_n && out_valid && !out_stall)
			sb.check_reply(status, read_value, hashed_bucket);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Offer one beat after a random gap and hold it until taken; valid stays high.
	task automatic send_op(kind_t op, logic [63:0] chars, logic [3:0] len,
			logic signed [31:0] val, logic [7:0] lvl, logic [4:0] bidx);
		int gap;
		if (sent_count % 50 == 0)
			send_eager = ($urandom_range(0, 2) == 0);
		sent_count++;
		gap = send_eager ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= op;
		name_chars <= chars;
		name_length <= len;
		new_value <= val;
		scope_level <= lvl;
		bucket_index <= bidx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Receiver: random stall before each beat, one long hold-off to back up the block.
	initial begin
		int gap;
		int taken;
		bit eager;
		taken = 0;
		eager = 1'b0;
		out_stall = 1'b0;
		forever begin
			if (taken % 40 == 0)
				eager = ($urandom_range(0, 2) == 0);
			gap = eager ? 0 : $urandom_range(0, 11);
			if (taken == 150)
				gap = LONG_HOLD;
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
		end
	end

	initial begin
		logic [63:0] pool_chars  [POOL_SIZE];
		logic [3:0]  pool_len    [POOL_SIZE];
		logic [4:0]  pool_bucket [POOL_SIZE];
		logic [63:0] chars;
		logic [3:0]  len;
		logic [7:0]  lvl;
		logic [4:0]  bidx;
		logic [4:0]  q_bucket;
		kind_t       op;
		int          p;
		int          pick;

		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_INSERT;
		name_chars = '0;
		name_length = '0;
		new_value = '0;
		scope_level = '0;
		bucket_index = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty name, saturated long name, masked tail bytes, misses,
		// a bucket filled past capacity with duplicates, and every pop outcome.
		send_op(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'sh7FFF_FFFF, 8'd0, 5'd0);
		send_op(KIND_SEARCH, 64'h0, 4'd0, 32'sd0, 8'd0, 5'd0);
		send_op(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'sh8000_0000, 8'd255, 5'd31);
		send_op(KIND_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'sd0, 8'd255, 5'd0);
		send_op(KIND_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'sd0, 8'd254, 5'd0);
		send_op(KIND_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, -32'sd1, 8'd255, 5'd0);
		send_op(KIND_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 4'd12, 32'sd0, 8'd255, 5'd0);
		send_op(KIND_UPDATE, 64'h0102, 4'd2, 32'sd9, 8'd7, 5'd0);
		send_op(KIND_INSERT, 64'hDEAD_BEEF_CAFE_0061, 4'd1, 32'sd5, 8'd9, 5'd0);
		send_op(KIND_SEARCH, 64'h61, 4'd1, 32'sd0, 8'd9, 5'd0);
		for (int i = 0; i < SLOTS_PER_BUCKET + 1; i++)
			send_op(KIND_INSERT, 64'h71, 4'd1, 100 + i, 8'd1, 5'd0);
		send_op(KIND_SEARCH, 64'h71, 4'd1, 32'sd0, 8'd1, 5'd0);
		send_op(KIND_UPDATE, 64'h71, 4'd1, 32'sd42, 8'd1, 5'd0);
		send_op(KIND_SEARCH, 64'h71, 4'd1, 32'sd0, 8'd1, 5'd0);
		q_bucket = 5'(sb.bucket_for(64'h71, 1));
		send_op(KIND_POP, 64'h0, 4'd0, 32'sd0, 8'd1, q_bucket);
		send_op(KIND_POP, 64'h0, 4'd0, 32'sd0, 8'd0, 5'd31);
		send_op(KIND_POP, 64'h0, 4'd0, 32'sd0, 8'd77, q_bucket);
		send_op(KIND_SEARCH, 64'h71, 4'd1, 32'sd0, 8'd1, 5'd0);

		for (int round = 0; round < 4; round++) begin
			// Half the names collide in one bucket so it fills and overflows.
			for (int i = 0; i < POOL_SIZE; i++) begin
				do begin
					pool_len[i] = (i == POOL_SIZE - 1) ? 4'd0 : 4'($urandom_range(1, 8));
					pool_chars[i] = {$urandom, $urandom};
					if (pool_len[i] < 8)
						pool_chars[i] &= (64'd1 << (8 * pool_len[i])) - 64'd1;
					pool_bucket[i] = 5'(sb.bucket_for(pool_chars[i], pool_len[i]));
				end while (i > 0 && i < POOL_SIZE / 2 && pool_bucket[i] != pool_bucket[0]);
			end

			if (round == 2) begin
				in_valid <= 1'b0;
				while (sb.replies_due.size() != 0) @(posedge clk);
			end

			for (int n = 0; n < ROUND_ITEMS; n++) begin
				if ($urandom_range(0, 9) == 0) begin
					send_op(kind_t'($urandom_range(0, 3)), {$urandom, $urandom},
						4'($urandom_range(0, 15)), $urandom, 8'($urandom_range(0, 255)),
						5'($urandom_range(0, 31)));
				end else begin
					p = $urandom_range(0, POOL_SIZE - 1);
					chars = pool_chars[p];
					len = pool_len[p];
					if (len == 8 && $urandom_range(0, 3) == 0)
						len = 4'($urandom_range(9, 15));
					else if (len < 8 && $urandom_range(0, 2) == 0)
						chars |= {$urandom, $urandom} << (8 * len);
					lvl = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
						: 8'($urandom_range(0, 3));
					pick = $urandom_range(0, 9);
					op = (pick < 3) ? KIND_INSERT : (pick < 6) ? KIND_SEARCH
						: (pick < 8) ? KIND_UPDATE : KIND_POP;
					bidx = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(0, 31))
						: pool_bucket[p];
					send_op(op, chars, len, $urandom, lvl, bidx);
				end
			end
		end

		in_valid <= 1'b0;
		while (sb.replies_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.faults == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/ssht_pkg.sv
rtl/core/ssht_hash.sv
rtl/core/scoped_symbol_hash_table_unit.sv
tb/sv/scoped_symbol_hash_table_unit_test.sv
